### src/tcf_pkg.sv
// Shared types, widths and constants for the two-charge field pipeline.
// No dependencies; used by tcf_div and two_charge_field_at_grid_point.
package tcf_pkg;

    // Field widths of the input and result words.
    localparam int IDX_W     = 6;
    localparam int COORD_W   = 16;
    localparam int STR_W     = 32;
    localparam int FIELD_W   = 48;

    // Internal widths, sized from the value ranges.
    localparam int DIFF_W    = COORD_W + 1;     // point minus charge position
    localparam int DIST_W    = COORD_W;         // |rx| is at most 49152
    localparam int SQ_W      = 2 * DIST_W;      // rx^2
    localparam int R2_W      = SQ_W + 1;        // rx^2 + ry^2
    localparam int RQ_FRAC   = 16;              // r2 is scaled by 2^16 before the root
    localparam int RAD1_W    = R2_W + RQ_FRAC;
    localparam int RQ_W      = 25;              // bits of |r| in units of 2^-22
    localparam int DEN_W     = R2_W + RQ_W;     // |r|^3
    localparam int PROD_W    = STR_W + DIST_W;  // |S| * |rc|
    localparam int Q_W       = 51;              // quotient bits kept, cap included
    localparam int PLO_W     = 7;               // numerator bits below the first quotient bit
    localparam int DIV_LAT   = Q_W + 1;
    localparam int CONTRIB_W = Q_W + 1;
    localparam int FSUM_W    = CONTRIB_W + 1;
    localparam int FABS_W    = FSUM_W - 1;
    localparam int HALF_W    = FABS_W / 2;
    localparam int PP_W      = 2 * HALF_W;
    localparam int RAD2_W    = 2 * FABS_W;
    localparam int MAG_RW    = FABS_W;

    // Pipeline depth from an accepted word to its result.
    localparam int LAT = 4 + RQ_W + 1 + DIV_LAT + 5 + MAG_RW + 1;

    typedef logic        [IDX_W-1:0]     idx_t;
    typedef logic signed [COORD_W-1:0]   coord_t;
    typedef logic signed [DIFF_W-1:0]    diff_t;
    typedef logic        [DIST_W-1:0]    dist_t;
    typedef logic        [SQ_W-1:0]      sq_t;
    typedef logic        [R2_W-1:0]      r2_t;
    typedef logic        [RQ_W-1:0]      rq_t;
    typedef logic        [DEN_W-1:0]     den_t;
    typedef logic        [STR_W-1:0]     smag_t;
    typedef logic        [PROD_W-1:0]    prod_t;
    typedef logic        [Q_W-1:0]       quo_t;
    typedef logic        [PLO_W-1:0]     plo_t;
    typedef logic signed [CONTRIB_W-1:0] contrib_t;
    typedef logic signed [FSUM_W-1:0]    fsum_t;
    typedef logic        [FABS_W-1:0]    fabs_t;
    typedef logic        [HALF_W-1:0]    half_t;
    typedef logic        [PP_W-1:0]      pp_t;
    typedef logic        [RAD2_W-1:0]    rad2_t;
    typedef logic        [MAG_RW-1:0]    root2_t;
    typedef logic signed [FIELD_W-1:0]   field_t;
    typedef logic        [FIELD_W-1:0]   mag_t;

    // Largest contribution magnitude, 2^50.
    localparam quo_t QUO_CAP = quo_t'(1) << (Q_W - 1);

    // Saturation limits of the field and magnitude outputs.
    localparam fsum_t FSUM_MAX = fsum_t'((64'sd1 <<< (FIELD_W - 1)) - 64'sd1);
    localparam fsum_t FSUM_MIN = fsum_t'(-(64'sd1 <<< (FIELD_W - 1)));
    localparam mag_t  MAG_MAX  = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_POS_X        = 3'd0;
    localparam cfg_idx_t REG_POS_Y        = 3'd1;
    localparam cfg_idx_t REG_POS_STRENGTH = 3'd2;
    localparam cfg_idx_t REG_NEG_X        = 3'd3;
    localparam cfg_idx_t REG_NEG_Y        = 3'd4;
    localparam cfg_idx_t REG_NEG_STRENGTH = 3'd5;

    // Input and result words.
    typedef struct packed {
        idx_t column;
        idx_t row;
    } item_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        field_t field_x;
        field_t field_y;
        mag_t   magnitude;
    } result_t;

    // Per-charge data carried alongside the distance root.
    typedef struct packed {
        logic  zero;
        logic  negx;
        logic  negy;
        prod_t prx;
        prod_t pry;
        r2_t   r2;
    } chg_side_t;

    // Flags carried alongside a division.
    typedef struct packed {
        logic zero;
        logic neg;
    } div_side_t;

    // Saturated field pair carried alongside the magnitude root.
    typedef struct packed {
        field_t fx;
        field_t fy;
    } field_pair_t;

endpackage

### src/tcf_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on nothing; instantiated by two_charge_field_at_grid_point.
module tcf_isqrt #(
    parameter int IN_W   = 49,
    parameter int RES_W  = 25,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic [RES_W-1:0]  root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int REM_W = ((IN_W > 2 * RES_W) ? IN_W : 2 * RES_W) + 1;

    logic [REM_W-1:0]  rem_reg  [RES_W-1];
    logic [RES_W-1:0]  res_reg  [RES_W];
    logic [SIDE_W-1:0] side_reg [RES_W];

    logic [REM_W-1:0]  rem_cur  [RES_W];
    logic [REM_W-1:0]  rem_next [RES_W];
    logic [REM_W-1:0]  trial    [RES_W];
    logic [RES_W-1:0]  res_cur  [RES_W];
    logic [RES_W-1:0]  res_next [RES_W];

    // Stage inputs: the first stage reads the ports, the others the previous stage.
    always_comb
    begin
        rem_cur[0] = REM_W'(radicand);
        res_cur[0] = '0;
        for (int s = 1; s < RES_W; s++)
        begin
            rem_cur[s] = rem_reg[s-1];
            res_cur[s] = res_reg[s-1];
        end
    end

    // Each stage tries one root bit, most significant first, on the running remainder.
    always_comb
    begin
        int b;
        for (int s = 0; s < RES_W; s++)
        begin
            b = RES_W - 1 - s;
            trial[s] = (REM_W'(res_cur[s]) << (b + 1)) + (REM_W'(1) << (2 * b));
            if (rem_cur[s] >= trial[s])
            begin
                rem_next[s] = rem_cur[s] - trial[s];
                res_next[s] = res_cur[s] | (RES_W'(1) << b);
            end
            else
            begin
                rem_next[s] = rem_cur[s];
                res_next[s] = res_cur[s];
            end
        end
    end

    // Stage registers move together when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 0; s < RES_W; s++)
            begin
                res_reg[s] <= res_next[s];
            end
            for (int s = 0; s < RES_W - 1; s++)
            begin
                rem_reg[s] <= rem_next[s];
            end
            for (int s = 1; s < RES_W; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign root     = res_reg[RES_W-1];
    assign side_out = side_reg[RES_W-1];

endmodule

### src/tcf_div.sv
// Pipelined restoring divider for one field contribution, capped at 2^50.
// Depends on tcf_pkg; instantiated by two_charge_field_at_grid_point.
module tcf_div #(
    parameter int SIDE_W = 2
) (
    input  logic                clk,
    input  logic                en,
    input  tcf_pkg::prod_t      num,
    input  tcf_pkg::den_t       den,
    input  logic [SIDE_W-1:0]   side_in,
    output tcf_pkg::quo_t       quo,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int QN = tcf_pkg::Q_W;

    // The dividend is num * 2^44. Its part above the kept quotient bits is num >> 7,
    // and the seven low bits of num are shifted in over the first steps.
    tcf_pkg::den_t     rem_reg  [QN];
    tcf_pkg::den_t     den_reg  [QN];
    tcf_pkg::plo_t     plo_reg  [QN];
    tcf_pkg::quo_t     q_reg    [QN+1];
    logic              ovf_reg  [QN+1];
    logic [SIDE_W-1:0] side_reg [QN+1];

    logic [tcf_pkg::DEN_W:0] sh       [QN];
    tcf_pkg::den_t           rem_next [QN];
    tcf_pkg::quo_t           q_next   [QN];

    // One quotient bit per stage.
    always_comb
    begin
        for (int s = 0; s < QN; s++)
        begin
            sh[s] = {rem_reg[s], plo_reg[s][tcf_pkg::PLO_W-1]};
            if (sh[s] >= {1'b0, den_reg[s]})
            begin
                rem_next[s] = tcf_pkg::den_t'(sh[s] - {1'b0, den_reg[s]});
                q_next[s]   = {q_reg[s][QN-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = tcf_pkg::den_t'(sh[s]);
                q_next[s]   = {q_reg[s][QN-2:0], 1'b0};
            end
        end
    end

    // Entry stage flags a quotient of 2^51 or more, then the step stages follow.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= tcf_pkg::den_t'(num[tcf_pkg::PROD_W-1:tcf_pkg::PLO_W]);
            den_reg[0]  <= den;
            plo_reg[0]  <= num[tcf_pkg::PLO_W-1:0];
            q_reg[0]    <= '0;
            ovf_reg[0]  <= tcf_pkg::den_t'(num[tcf_pkg::PROD_W-1:tcf_pkg::PLO_W]) >= den;
            side_reg[0] <= side_in;
            for (int s = 1; s < QN; s++)
            begin
                rem_reg[s] <= rem_next[s-1];
                den_reg[s] <= den_reg[s-1];
                plo_reg[s] <= plo_reg[s-1] << 1;
            end
            for (int s = 1; s <= QN; s++)
            begin
                q_reg[s]    <= q_next[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // Hold large quotients at the cap.
    always_comb
    begin
        if (ovf_reg[QN] || (q_reg[QN] > tcf_pkg::QUO_CAP))
        begin
            quo = tcf_pkg::QUO_CAP;
        end
        else
        begin
            quo = q_reg[QN];
        end
    end

    assign side_out = side_reg[QN];

endmodule

### src/two_charge_field_at_grid_point.sv
// Top level: electric field of two point charges at one grid point, fully pipelined.
// Depends on tcf_pkg, tcf_isqrt and tcf_div.
//
// Usage. A word on the item channel carries a grid column and row. The block maps
// them to a Q2.14 position across -1..1 and returns the position, the summed field
// Ex, Ey of both charges and its magnitude, all field values times 2^8 and saturated.
// A word is taken when item_valid is high and item_stall is low; a result word is
// taken when result_valid is high and result_stall is low.
// Charge positions and strengths are written on the cfg port (cfg_ready is always
// high) while no word is in flight.
// Throughput is one word per cycle while no result is stalled. Most of the depth is the
// distance root (25 stages, one bit each), the contribution dividers (52 stages: entry
// stage, then one quotient bit per stage) and the magnitude root (52 stages).
// Reset clears every valid bit and sets all charge registers to zero.
// While result_stall holds back a waiting result, the whole pipeline freezes and
// item_stall is raised; nothing is lost or repeated.
module two_charge_field_at_grid_point #(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  tcf_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output tcf_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  tcf_pkg::cfg_idx_t         cfg_index,
    input  logic [tcf_pkg::STR_W-1:0] cfg_data
);

    localparam int LAT      = tcf_pkg::LAT;
    localparam int NUM_CHG  = 2;
    localparam int CHG_POS  = 0;
    localparam int CHG_NEG  = 1;
    localparam int TAB_N    = 1 << tcf_pkg::IDX_W;
    localparam int SPAN     = 32768;
    localparam int HALF     = 16384;
    localparam int LAST_COL = GRID_COLUMNS - 1;
    localparam int LAST_ROW = GRID_ROWS - 1;

    // Sign applied to a capped quotient; a charge on the point gives nothing.
    function automatic tcf_pkg::contrib_t to_contrib(input tcf_pkg::quo_t q,
                                                     input tcf_pkg::div_side_t sd);
        tcf_pkg::contrib_t mag;
        mag = tcf_pkg::contrib_t'(q);
        if (sd.zero)
        begin
            return '0;
        end
        else if (sd.neg)
        begin
            return -mag;
        end
        return mag;
    endfunction

    logic adv;
    logic valid_reg [LAT];

    tcf_pkg::coord_t chg_x_reg    [NUM_CHG];
    tcf_pkg::coord_t chg_y_reg    [NUM_CHG];
    tcf_pkg::smag_t  chg_smag_reg [NUM_CHG];
    logic            chg_sneg_reg [NUM_CHG];

    tcf_pkg::coord_t col_pos [TAB_N];
    tcf_pkg::coord_t row_pos [TAB_N];
    tcf_pkg::coord_t px_reg  [LAT];
    tcf_pkg::coord_t py_reg  [LAT];

    tcf_pkg::contrib_t contrib_x [NUM_CHG];
    tcf_pkg::contrib_t contrib_y [NUM_CHG];

    tcf_pkg::fsum_t        sx_reg, sy_reg;
    tcf_pkg::fabs_t        ax_reg, ay_reg;
    tcf_pkg::field_t       satx_next, saty_next;
    tcf_pkg::field_pair_t  sat8_reg, sat9_reg, sat10_reg, sat_out;
    tcf_pkg::pp_t          hhx_reg, hlx_reg, llx_reg, hhy_reg, hly_reg, lly_reg;
    tcf_pkg::rad2_t        rad_reg;
    tcf_pkg::root2_t       mag_root;
    tcf_pkg::field_t       fx_out_reg, fy_out_reg;
    tcf_pkg::mag_t         mag_out_reg;

    // The pipeline moves unless a finished result is held back.
    assign adv          = !(valid_reg[LAT-1] && result_stall);
    assign item_stall   = !adv;
    assign result_valid = valid_reg[LAT-1];
    assign cfg_ready    = 1'b1;

    // Configuration registers; strengths are kept as magnitude and sign.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHG; k++)
            begin
                chg_x_reg[k]    <= '0;
                chg_y_reg[k]    <= '0;
                chg_smag_reg[k] <= '0;
                chg_sneg_reg[k] <= 1'b0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcf_pkg::REG_POS_X: chg_x_reg[CHG_POS] <= cfg_data[tcf_pkg::COORD_W-1:0];
                tcf_pkg::REG_POS_Y: chg_y_reg[CHG_POS] <= cfg_data[tcf_pkg::COORD_W-1:0];
                tcf_pkg::REG_POS_STRENGTH:
                begin
                    chg_smag_reg[CHG_POS] <= cfg_data[tcf_pkg::STR_W-1] ? (~cfg_data + 1'b1)
                                                                        : cfg_data;
                    chg_sneg_reg[CHG_POS] <= cfg_data[tcf_pkg::STR_W-1];
                end
                tcf_pkg::REG_NEG_X: chg_x_reg[CHG_NEG] <= cfg_data[tcf_pkg::COORD_W-1:0];
                tcf_pkg::REG_NEG_Y: chg_y_reg[CHG_NEG] <= cfg_data[tcf_pkg::COORD_W-1:0];
                tcf_pkg::REG_NEG_STRENGTH:
                begin
                    chg_smag_reg[CHG_NEG] <= cfg_data[tcf_pkg::STR_W-1] ? (~cfg_data + 1'b1)
                                                                        : cfg_data;
                    chg_sneg_reg[CHG_NEG] <= cfg_data[tcf_pkg::STR_W-1];
                end
                default: ;
            endcase
        end
    end

    // Index-to-position tables, rounded half up and clamped to the last index.
    for (genvar i = 0; i < TAB_N; i++)
    begin : g_tab
        localparam int CI = (i > LAST_COL) ? LAST_COL : i;
        localparam int RI = (i > LAST_ROW) ? LAST_ROW : i;
        localparam int CV = (CI * SPAN + LAST_COL / 2) / LAST_COL - HALF;
        localparam int RV = (RI * SPAN + LAST_ROW / 2) / LAST_ROW - HALF;
        assign col_pos[i] = tcf_pkg::coord_t'(CV);
        assign row_pos[i] = tcf_pkg::coord_t'(RV);
    end

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= item_valid;
            for (int s = 1; s < LAT; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Grid position: looked up at entry and delayed to the result.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= col_pos[item.column];
            py_reg[0] <= row_pos[item.row];
            for (int s = 1; s < LAT; s++)
            begin
                px_reg[s] <= px_reg[s-1];
                py_reg[s] <= py_reg[s-1];
            end
        end
    end

    // One contribution path per charge.
    for (genvar k = 0; k < NUM_CHG; k++)
    begin : g_chg
        tcf_pkg::diff_t        rx, ry;
        tcf_pkg::dist_t        arx_reg, ary_reg;
        logic                  rxn_reg, ryn_reg;
        tcf_pkg::sq_t          sqx_reg, sqy_reg;
        tcf_pkg::prod_t        prx_reg, pry_reg;
        logic                  negx_reg, negy_reg;
        tcf_pkg::r2_t          r2_reg;
        tcf_pkg::prod_t        prx4_reg, pry4_reg;
        logic                  negx4_reg, negy4_reg;
        tcf_pkg::chg_side_t    sq_side_in, sq_side_out;
        tcf_pkg::rq_t          rq;
        tcf_pkg::den_t         den_reg;
        tcf_pkg::prod_t        prx5_reg, pry5_reg;
        tcf_pkg::div_side_t    dx_side_reg, dy_side_reg, dx_side_out, dy_side_out;
        tcf_pkg::quo_t         qx, qy;
        tcf_pkg::contrib_t     cx_reg, cy_reg;

        // Offset from the charge to the grid point.
        always_comb
        begin
            rx = tcf_pkg::diff_t'({px_reg[0][tcf_pkg::COORD_W-1], px_reg[0]})
               - tcf_pkg::diff_t'({chg_x_reg[k][tcf_pkg::COORD_W-1], chg_x_reg[k]});
            ry = tcf_pkg::diff_t'({py_reg[0][tcf_pkg::COORD_W-1], py_reg[0]})
               - tcf_pkg::diff_t'({chg_y_reg[k][tcf_pkg::COORD_W-1], chg_y_reg[k]});
        end

        // Absolute offsets, squares, strength products and the distance squared.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                arx_reg   <= rx[tcf_pkg::DIFF_W-1] ? tcf_pkg::dist_t'(-rx)
                                                   : tcf_pkg::dist_t'(rx);
                ary_reg   <= ry[tcf_pkg::DIFF_W-1] ? tcf_pkg::dist_t'(-ry)
                                                   : tcf_pkg::dist_t'(ry);
                rxn_reg   <= rx[tcf_pkg::DIFF_W-1];
                ryn_reg   <= ry[tcf_pkg::DIFF_W-1];

                sqx_reg   <= tcf_pkg::sq_t'(arx_reg) * tcf_pkg::sq_t'(arx_reg);
                sqy_reg   <= tcf_pkg::sq_t'(ary_reg) * tcf_pkg::sq_t'(ary_reg);
                prx_reg   <= tcf_pkg::prod_t'(chg_smag_reg[k]) * tcf_pkg::prod_t'(arx_reg);
                pry_reg   <= tcf_pkg::prod_t'(chg_smag_reg[k]) * tcf_pkg::prod_t'(ary_reg);
                negx_reg  <= chg_sneg_reg[k] ^ rxn_reg;
                negy_reg  <= chg_sneg_reg[k] ^ ryn_reg;

                r2_reg    <= tcf_pkg::r2_t'(sqx_reg) + tcf_pkg::r2_t'(sqy_reg);
                prx4_reg  <= prx_reg;
                pry4_reg  <= pry_reg;
                negx4_reg <= negx_reg;
                negy4_reg <= negy_reg;
            end
        end

        always_comb
        begin
            sq_side_in.zero = (r2_reg == '0);
            sq_side_in.negx = negx4_reg;
            sq_side_in.negy = negy4_reg;
            sq_side_in.prx  = prx4_reg;
            sq_side_in.pry  = pry4_reg;
            sq_side_in.r2   = r2_reg;
        end

        // Distance |r| in units of 2^-22.
        tcf_isqrt #(
            .IN_W   (tcf_pkg::RAD1_W),
            .RES_W  (tcf_pkg::RQ_W),
            .SIDE_W ($bits(tcf_pkg::chg_side_t))
        ) u_dist_root (
            .clk      (clk),
            .en       (adv),
            .radicand ({r2_reg, {tcf_pkg::RQ_FRAC{1'b0}}}),
            .side_in  (sq_side_in),
            .root     (rq),
            .side_out (sq_side_out)
        );

        // Cube of the distance.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg          <= tcf_pkg::den_t'(sq_side_out.r2) * tcf_pkg::den_t'(rq);
                prx5_reg         <= sq_side_out.prx;
                pry5_reg         <= sq_side_out.pry;
                dx_side_reg.zero <= sq_side_out.zero;
                dx_side_reg.neg  <= sq_side_out.negx;
                dy_side_reg.zero <= sq_side_out.zero;
                dy_side_reg.neg  <= sq_side_out.negy;
            end
        end

        tcf_div #(
            .SIDE_W ($bits(tcf_pkg::div_side_t))
        ) u_div_x (
            .clk      (clk),
            .en       (adv),
            .num      (prx5_reg),
            .den      (den_reg),
            .side_in  (dx_side_reg),
            .quo      (qx),
            .side_out (dx_side_out)
        );

        tcf_div #(
            .SIDE_W ($bits(tcf_pkg::div_side_t))
        ) u_div_y (
            .clk      (clk),
            .en       (adv),
            .num      (pry5_reg),
            .den      (den_reg),
            .side_in  (dy_side_reg),
            .quo      (qy),
            .side_out (dy_side_out)
        );

        // Signed contribution of this charge.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg <= to_contrib(qx, dx_side_out);
                cy_reg <= to_contrib(qy, dy_side_out);
            end
        end

        assign contrib_x[k] = cx_reg;
        assign contrib_y[k] = cy_reg;
    end

    // Saturated field components.
    always_comb
    begin
        priority if (sx_reg > tcf_pkg::FSUM_MAX)
            satx_next = tcf_pkg::field_t'(tcf_pkg::FSUM_MAX);
        else if (sx_reg < tcf_pkg::FSUM_MIN)
            satx_next = tcf_pkg::field_t'(tcf_pkg::FSUM_MIN);
        else
            satx_next = tcf_pkg::field_t'(sx_reg);

        priority if (sy_reg > tcf_pkg::FSUM_MAX)
            saty_next = tcf_pkg::field_t'(tcf_pkg::FSUM_MAX);
        else if (sy_reg < tcf_pkg::FSUM_MIN)
            saty_next = tcf_pkg::field_t'(tcf_pkg::FSUM_MIN);
        else
            saty_next = tcf_pkg::field_t'(sy_reg);
    end

    // Exact sums, absolute values, split squares and the sum of squares.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg <= tcf_pkg::fsum_t'(contrib_x[CHG_POS]) + tcf_pkg::fsum_t'(contrib_x[CHG_NEG]);
            sy_reg <= tcf_pkg::fsum_t'(contrib_y[CHG_POS]) + tcf_pkg::fsum_t'(contrib_y[CHG_NEG]);

            ax_reg      <= sx_reg[tcf_pkg::FSUM_W-1] ? tcf_pkg::fabs_t'(-sx_reg)
                                                     : tcf_pkg::fabs_t'(sx_reg);
            ay_reg      <= sy_reg[tcf_pkg::FSUM_W-1] ? tcf_pkg::fabs_t'(-sy_reg)
                                                     : tcf_pkg::fabs_t'(sy_reg);
            sat8_reg.fx <= satx_next;
            sat8_reg.fy <= saty_next;

            hhx_reg  <= tcf_pkg::pp_t'(ax_reg[tcf_pkg::FABS_W-1:tcf_pkg::HALF_W])
                      * tcf_pkg::pp_t'(ax_reg[tcf_pkg::FABS_W-1:tcf_pkg::HALF_W]);
            hlx_reg  <= tcf_pkg::pp_t'(ax_reg[tcf_pkg::FABS_W-1:tcf_pkg::HALF_W])
                      * tcf_pkg::pp_t'(ax_reg[tcf_pkg::HALF_W-1:0]);
            llx_reg  <= tcf_pkg::pp_t'(ax_reg[tcf_pkg::HALF_W-1:0])
                      * tcf_pkg::pp_t'(ax_reg[tcf_pkg::HALF_W-1:0]);
            hhy_reg  <= tcf_pkg::pp_t'(ay_reg[tcf_pkg::FABS_W-1:tcf_pkg::HALF_W])
                      * tcf_pkg::pp_t'(ay_reg[tcf_pkg::FABS_W-1:tcf_pkg::HALF_W]);
            hly_reg  <= tcf_pkg::pp_t'(ay_reg[tcf_pkg::FABS_W-1:tcf_pkg::HALF_W])
                      * tcf_pkg::pp_t'(ay_reg[tcf_pkg::HALF_W-1:0]);
            lly_reg  <= tcf_pkg::pp_t'(ay_reg[tcf_pkg::HALF_W-1:0])
                      * tcf_pkg::pp_t'(ay_reg[tcf_pkg::HALF_W-1:0]);
            sat9_reg <= sat8_reg;

            rad_reg   <= ((tcf_pkg::rad2_t'(hhx_reg) + tcf_pkg::rad2_t'(hhy_reg))
                          << (2 * tcf_pkg::HALF_W))
                       + ((tcf_pkg::rad2_t'(hlx_reg) + tcf_pkg::rad2_t'(hly_reg))
                          << (tcf_pkg::HALF_W + 1))
                       + tcf_pkg::rad2_t'(llx_reg) + tcf_pkg::rad2_t'(lly_reg);
            sat10_reg <= sat9_reg;
        end
    end

    // Field magnitude.
    tcf_isqrt #(
        .IN_W   (tcf_pkg::RAD2_W),
        .RES_W  (tcf_pkg::MAG_RW),
        .SIDE_W ($bits(tcf_pkg::field_pair_t))
    ) u_mag_root (
        .clk      (clk),
        .en       (adv),
        .radicand (rad_reg),
        .side_in  (sat10_reg),
        .root     (mag_root),
        .side_out (sat_out)
    );

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_out_reg  <= sat_out.fx;
            fy_out_reg  <= sat_out.fy;
            mag_out_reg <= (mag_root > tcf_pkg::root2_t'(tcf_pkg::MAG_MAX))
                           ? tcf_pkg::MAG_MAX : tcf_pkg::mag_t'(mag_root);
        end
    end

    always_comb
    begin
        result.point_x   = px_reg[LAT-1];
        result.point_y   = py_reg[LAT-1];
        result.field_x   = fx_out_reg;
        result.field_y   = fy_out_reg;
        result.magnitude = mag_out_reg;
    end

endmodule
